>>> rtl/gbts_pkg.sv
`timescale 1ns / 1ps

package gbts_pkg;

   // Default text capacity in bytes.
   localparam int DEFAULT_CAPACITY = 4096;

   // Fixed field widths.
   localparam int BYTE_W = 8;
   localparam int CMD_W  = 3;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_PUT    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SEEK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_PREV   = 3'd5;

   // Per-cycle operation applied to every cell of one chain.
   typedef logic [1:0] chain_op_type;
   localparam chain_op_type OP_HOLD = 2'd0;
   localparam chain_op_type OP_PUSH = 2'd1;
   localparam chain_op_type OP_POP  = 2'd2;

   // Control bundle from the sequencer to one chain.
   typedef struct packed {
      chain_op_type            op;
      logic [BYTE_W-1:0]       push_data;
   } chain_ctl_type;

endpackage

>>> rtl/gbts_cell.sv
`timescale 1ns / 1ps

module gbts_cell (
   input  logic                        clock,
   input  gbts_pkg::chain_op_type      op,
   input  logic [gbts_pkg::BYTE_W-1:0] up_data,
   input  logic [gbts_pkg::BYTE_W-1:0] down_data,
   output logic [gbts_pkg::BYTE_W-1:0] q
);

   logic [gbts_pkg::BYTE_W-1:0] data_ff;
   logic [gbts_pkg::BYTE_W-1:0] data_in;

   // A push takes the byte from the neighbor nearer the top; a pop takes
   // the byte from the neighbor farther from the top.
   always_comb begin
      case (op)
         gbts_pkg::OP_PUSH: data_in = up_data;
         gbts_pkg::OP_POP:  data_in = down_data;
         default:           data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;

endmodule

>>> rtl/gbts_chain.sv
`timescale 1ns / 1ps

module gbts_chain #(
   parameter int DEPTH = gbts_pkg::DEFAULT_CAPACITY
) (
   input  logic                        clock,
   input  gbts_pkg::chain_ctl_type     ctl,
   output logic [gbts_pkg::BYTE_W-1:0] top
);

   logic [gbts_pkg::BYTE_W-1:0] cell_q [DEPTH];

   // Row of cells forming a stack; cell 0 holds the top byte.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [gbts_pkg::BYTE_W-1:0] up_data;
      logic [gbts_pkg::BYTE_W-1:0] down_data;

      if (i == 0) begin : g_first
         assign up_data = ctl.push_data;
      end else begin : g_inner_up
         assign up_data = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign down_data = cell_q[i];
      end else begin : g_inner_down
         assign down_data = cell_q[i+1];
      end

      gbts_cell u_cell (
         .clock     (clock),
         .op        (ctl.op),
         .up_data   (up_data),
         .down_data (down_data),
         .q         (cell_q[i])
      );
   end

   assign top = cell_q[0];

endmodule

>>> rtl/gap_buffer_text_store.sv
`timescale 1ns / 1ps

// Gap-buffer text store with a command interface.
// A transaction is taken at a rising edge where start is high and busy is
// low; req_cmd selects put, insert, delete, seek, next or previous, and
// req_byte_in, req_del_count and req_seek_pos carry the operands.
// Every transaction yields exactly one result: rsp_strobe is high for one
// cycle with the byte at the cursor, the text length, the cursor and the
// error flag. The receiver cannot stall, so a result is gone after its cycle.
// The text lives in two stacks built as rows of cells, one left of the gap
// and one right of it; the gap always sits at the cursor and every cell
// shifts one byte per cycle. Put, insert, next, previous, unused and refused
// commands, a delete of zero bytes and a seek to the cursor respond in the
// cycle after acceptance, so they can be issued every cycle. A delete of n
// bytes or a seek over d bytes spends its first cycle taking the target and
// then moves one byte per cycle through the cell chains; the next command
// can be taken from its result cycle on.
// Busy is high from the cycle after acceptance until the result cycle.
// Reset empties the text and sets the cursor to zero.
module gap_buffer_text_store #(
   parameter int CAPACITY = gbts_pkg::DEFAULT_CAPACITY,
   parameter int POS_W    = $clog2(CAPACITY + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [gbts_pkg::CMD_W-1:0]  req_cmd,
   input  logic [gbts_pkg::BYTE_W-1:0] req_byte_in,
   input  logic [POS_W-1:0]            req_del_count,
   input  logic [POS_W-1:0]            req_seek_pos,
   output logic                        rsp_strobe,
   output logic [gbts_pkg::BYTE_W-1:0] rsp_byte_out,
   output logic [POS_W-1:0]            rsp_text_len,
   output logic [POS_W-1:0]            rsp_cursor_pos,
   output logic                        rsp_error
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SEEK = 2'd1;
   localparam logic [1:0] ST_DEL  = 2'd2;

   localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);
   localparam logic [POS_W-1:0] ONE     = POS_W'(1);

   logic [1:0]       state_ff, state_in;
   logic [POS_W-1:0] cursor_ff, cursor_in;
   logic [POS_W-1:0] len_ff, len_in;
   logic [POS_W-1:0] target_ff, target_in;
   logic             strobe_ff, strobe_in;
   logic             err_ff, err_in;

   gbts_pkg::chain_ctl_type     left_ctl, right_ctl;
   logic [gbts_pkg::BYTE_W-1:0] left_top, right_top;
   logic                        full;

   assign full = (len_ff == CAP_POS);

   // Left stack holds the bytes before the cursor, right stack the rest.
   gbts_chain #(.DEPTH(CAPACITY)) u_left (
      .clock (clock),
      .ctl   (left_ctl),
      .top   (left_top)
   );

   gbts_chain #(.DEPTH(CAPACITY)) u_right (
      .clock (clock),
      .ctl   (right_ctl),
      .top   (right_top)
   );

   // Command decode and the sequencer for delete and seek steps.
   always_comb begin
      state_in            = state_ff;
      cursor_in           = cursor_ff;
      len_in              = len_ff;
      target_in           = target_ff;
      strobe_in           = 1'b0;
      err_in              = err_ff;
      left_ctl.op         = gbts_pkg::OP_HOLD;
      left_ctl.push_data  = right_top;
      right_ctl.op        = gbts_pkg::OP_HOLD;
      right_ctl.push_data = left_top;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               strobe_in = 1'b1;
               err_in    = 1'b0;
               case (req_cmd)
                  gbts_pkg::CMD_PUT: begin
                     if (full) begin
                        err_in = 1'b1;
                     end else begin
                        left_ctl.op        = gbts_pkg::OP_PUSH;
                        left_ctl.push_data = req_byte_in;
                        cursor_in          = cursor_ff + ONE;
                        len_in             = len_ff + ONE;
                     end
                  end
                  gbts_pkg::CMD_INSERT: begin
                     if (full) begin
                        err_in = 1'b1;
                     end else begin
                        right_ctl.op        = gbts_pkg::OP_PUSH;
                        right_ctl.push_data = req_byte_in;
                        len_in              = len_ff + ONE;
                     end
                  end
                  gbts_pkg::CMD_DELETE: begin
                     if (req_del_count > cursor_ff) begin
                        err_in = 1'b1;
                     end else if (req_del_count != '0) begin
                        strobe_in = 1'b0;
                        target_in = req_del_count;
                        state_in  = ST_DEL;
                     end
                  end
                  gbts_pkg::CMD_SEEK: begin
                     if (req_seek_pos > len_ff) begin
                        err_in = 1'b1;
                     end else if (req_seek_pos != cursor_ff) begin
                        strobe_in = 1'b0;
                        target_in = req_seek_pos;
                        state_in  = ST_SEEK;
                     end
                  end
                  gbts_pkg::CMD_NEXT: begin
                     if (cursor_ff != len_ff) begin
                        left_ctl.op  = gbts_pkg::OP_PUSH;
                        right_ctl.op = gbts_pkg::OP_POP;
                        cursor_in    = cursor_ff + ONE;
                     end
                  end
                  gbts_pkg::CMD_PREV: begin
                     if (cursor_ff != '0) begin
                        left_ctl.op  = gbts_pkg::OP_POP;
                        right_ctl.op = gbts_pkg::OP_PUSH;
                        cursor_in    = cursor_ff - ONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEEK: begin
            // Move one byte across the gap toward the target.
            if (cursor_ff > target_ff) begin
               left_ctl.op  = gbts_pkg::OP_POP;
               right_ctl.op = gbts_pkg::OP_PUSH;
               cursor_in    = cursor_ff - ONE;
            end else begin
               left_ctl.op  = gbts_pkg::OP_PUSH;
               right_ctl.op = gbts_pkg::OP_POP;
               cursor_in    = cursor_ff + ONE;
            end
            if (cursor_in == target_ff) begin
               state_in  = ST_IDLE;
               strobe_in = 1'b1;
            end
         end
         ST_DEL: begin
            // Drop one byte before the cursor per cycle.
            left_ctl.op = gbts_pkg::OP_POP;
            cursor_in   = cursor_ff - ONE;
            len_in      = len_ff - ONE;
            target_in   = target_ff - ONE;
            if (target_ff == ONE) begin
               state_in  = ST_IDLE;
               strobe_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cursor_ff <= '0;
         len_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         len_ff    <= len_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      err_ff    <= err_in;
   end

   // Result ports; the right stack top is the byte at the cursor.
   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_byte_out   = (cursor_ff == len_ff) ? '0 : right_top;
   assign rsp_text_len   = len_ff;
   assign rsp_cursor_pos = cursor_ff;
   assign rsp_error      = err_ff;

   // The cursor never passes the end of the text.
   a_cursor_in_text: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= len_ff)
      else $error("cursor beyond text length");

   // The text never exceeds the capacity.
   a_len_in_capacity: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CAP_POS)
      else $error("text length beyond capacity");

   // A result only appears once the sequencer has returned to idle.
   a_strobe_when_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> state_ff == ST_IDLE)
      else $error("result while busy");

   // A running delete always has bytes left to remove.
   a_del_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DEL |-> target_ff != '0)
      else $error("delete step with zero count");

   // An accepted put into a non-full buffer grows the text by one byte.
   a_put_grows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == gbts_pkg::CMD_PUT && !full)
      |=> len_ff == $past(len_ff) + ONE)
      else $error("put did not grow text");

endmodule
